// ----- sv/biquad_direct_form_two_assert.svh -----
// Assertion macros used by the biquad checker file.
`ifndef BIQUAD_DIRECT_FORM_TWO_ASSERT_SVH
`define BIQUAD_DIRECT_FORM_TWO_ASSERT_SVH

// Same-cycle implication, held off during reset
`define BQDF2_ASSERT_IMP(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
        else $error("biquad port check failed");

// Next-cycle implication, held off during reset
`define BQDF2_ASSERT_NXT(name, ck, rn, ante, cons) \
    name: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
        else $error("biquad port check failed");

`endif

// ----- sv/bqdf2_pkg.sv -----
// Shared constants, control word type and microcode program of the biquad.
package bqdf2_pkg;

    localparam int SAMPLE_BITS_DFLT = 24;
    localparam int STATE_BITS_DFLT  = 32;
    localparam int COEF_BITS        = 24;
    localparam int COEF_FRAC        = 21;
    localparam int CFG_IDX_BITS     = 3;
    localparam int STEP_BITS        = 3;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_FB_COEF_1 = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_FB_COEF_2 = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF_COEF_0 = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF_COEF_1 = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] REG_FF_COEF_2 = 3'd4;

    // Request types
    localparam logic REQ_SAMPLE = 1'b0;
    localparam logic REQ_LOAD   = 1'b1;

    // Coefficient operand select
    localparam logic [2:0] CSEL_FB1 = 3'd0;
    localparam logic [2:0] CSEL_FB2 = 3'd1;
    localparam logic [2:0] CSEL_FF0 = 3'd2;
    localparam logic [2:0] CSEL_FF1 = 3'd3;
    localparam logic [2:0] CSEL_FF2 = 3'd4;

    // State operand select
    localparam logic [1:0] SSEL_D1 = 2'd0;
    localparam logic [1:0] SSEL_D2 = 2'd1;
    localparam logic [1:0] SSEL_W  = 2'd2;

    // Accumulator operation
    localparam logic [1:0] ACC_HOLD = 2'd0;
    localparam logic [1:0] ACC_ADD  = 2'd1;
    localparam logic [1:0] ACC_CLR  = 2'd2;

    // Sequencing: advance, or finish when the output register is free and
    // otherwise jump to the target
    localparam logic JMP_SEQ      = 1'b0;
    localparam logic JMP_OUT_WAIT = 1'b1;

    typedef struct packed {
        logic [2:0]           coef_sel;
        logic [1:0]           st_sel;
        logic [1:0]           acc_op;
        logic                 w_wr;
        logic                 jmp_cond;
        logic [STEP_BITS-1:0] jmp_target;
    } ctrl_t;

    // Microcode program: one control word per step
    function automatic ctrl_t bqdf2_rom(input logic [STEP_BITS-1:0] step);
        ctrl_t cw;
        cw = '{coef_sel: CSEL_FB1, st_sel: SSEL_D1, acc_op: ACC_HOLD,
               w_wr: 1'b0, jmp_cond: JMP_SEQ, jmp_target: '0};
        unique case (step)
            3'd0:
            begin
                cw.coef_sel = CSEL_FB1;
                cw.st_sel   = SSEL_D1;
            end
            3'd1:
            begin
                cw.coef_sel = CSEL_FB2;
                cw.st_sel   = SSEL_D2;
                cw.acc_op   = ACC_ADD;
            end
            3'd2:
            begin
                cw.acc_op   = ACC_ADD;
            end
            3'd3:
            begin
                cw.coef_sel = CSEL_FF1;
                cw.st_sel   = SSEL_D1;
                cw.acc_op   = ACC_CLR;
                cw.w_wr     = 1'b1;
            end
            3'd4:
            begin
                cw.coef_sel = CSEL_FF2;
                cw.st_sel   = SSEL_D2;
                cw.acc_op   = ACC_ADD;
            end
            3'd5:
            begin
                cw.coef_sel = CSEL_FF0;
                cw.st_sel   = SSEL_W;
                cw.acc_op   = ACC_ADD;
            end
            3'd6:
            begin
                cw.acc_op   = ACC_ADD;
            end
            3'd7:
            begin
                cw.jmp_cond   = JMP_OUT_WAIT;
                cw.jmp_target = 3'd7;
            end
            default:
            begin
                cw.jmp_cond   = JMP_OUT_WAIT;
                cw.jmp_target = 3'd7;
            end
        endcase
        return cw;
    endfunction

endpackage

// ----- sv/biquad_direct_form_two.sv -----
// Samples: the eight microcode steps of a sample share one multiplier and one
// accumulator; the result is registered at the last step, which repeats while the
// output register is stalled, and no request is taken until then. Loads are taken
// one per cycle while the sequencer is idle and write both delay words on acceptance.
// Reset: coefficients and both delay words clear to zero, sequencer idle, no result held.
module biquad_direct_form_two
    import bqdf2_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT,
    parameter int STATE_BITS  = STATE_BITS_DFLT
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]       cfg_index,
    input  logic [COEF_BITS-1:0]          cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          req_type,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic signed [STATE_BITS-1:0]  load_first,
    input  logic signed [STATE_BITS-1:0]  load_second,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0] sample_out
);

    localparam int PROD_W  = COEF_BITS + STATE_BITS;
    localparam int ACC_A   = PROD_W + 2;
    localparam int ACC_B   = SAMPLE_BITS + COEF_FRAC + 2;
    localparam int ACC_W   = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int RND_W   = ACC_W - COEF_FRAC;

    logic signed [COEF_BITS-1:0]   fb1_reg, fb2_reg, ff0_reg, ff1_reg, ff2_reg;
    logic signed [STATE_BITS-1:0]  d1_reg, d2_reg, w_reg;
    logic signed [ACC_W-1:0]       acc_reg, acc_next;
    logic signed [PROD_W-1:0]      prod_reg;
    logic                          busy_reg, busy_next;
    logic [STEP_BITS-1:0]          step_reg, step_next;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] out_data_reg;

    ctrl_t                         ctrl;
    logic signed [COEF_BITS-1:0]   coef_op;
    logic signed [STATE_BITS-1:0]  st_op;
    logic signed [PROD_W-1:0]      prod;
    logic [ACC_W-1:0]              rnd_sum;
    logic [RND_W-1:0]              rnd;
    logic                          w_fits, y_fits;
    logic signed [STATE_BITS-1:0]  w_val;
    logic signed [SAMPLE_BITS-1:0] y_val;
    logic                          in_take, sample_take, load_take;
    logic                          out_stall, fire_out;

    assign in_ready    = !busy_reg;
    assign in_take     = in_valid && in_ready;
    assign sample_take = in_take && (req_type == REQ_SAMPLE);
    assign load_take   = in_take && (req_type == REQ_LOAD);
    assign out_valid   = out_valid_reg;
    assign sample_out  = out_data_reg;
    assign out_stall   = out_valid_reg && !out_ready;

    // Fetch the control word of the current step
    assign ctrl = bqdf2_rom(step_reg);

    // Select multiplier operands
    always_comb
    begin
        case (ctrl.coef_sel)
            CSEL_FB1: coef_op = fb1_reg;
            CSEL_FB2: coef_op = fb2_reg;
            CSEL_FF0: coef_op = ff0_reg;
            CSEL_FF1: coef_op = ff1_reg;
            CSEL_FF2: coef_op = ff2_reg;
            default:  coef_op = fb1_reg;
        endcase
        case (ctrl.st_sel)
            SSEL_D1: st_op = d1_reg;
            SSEL_D2: st_op = d2_reg;
            SSEL_W:  st_op = w_reg;
            default: st_op = d1_reg;
        endcase
    end

    assign prod = coef_op * st_op;

    // Round half up, dropping 21 fraction bits, then flush or saturate
    assign rnd_sum = acc_reg + {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    assign rnd     = rnd_sum[ACC_W-1:COEF_FRAC];
    assign w_fits  = (&rnd[RND_W-1:STATE_BITS-1]) || !(|rnd[RND_W-1:STATE_BITS-1]);
    assign y_fits  = (&rnd[RND_W-1:SAMPLE_BITS-1]) || !(|rnd[RND_W-1:SAMPLE_BITS-1]);
    assign w_val   = w_fits ? rnd[STATE_BITS-1:0] : '0;

    always_comb
    begin
        if (y_fits)
        begin
            y_val = rnd[SAMPLE_BITS-1:0];
        end
        else if (rnd[RND_W-1])
        begin
            y_val = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end
        else
        begin
            y_val = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    // Sequencer: start on a sample, advance, finish or hold on a busy output
    always_comb
    begin
        busy_next = busy_reg;
        step_next = step_reg;
        fire_out  = 1'b0;
        if (sample_take)
        begin
            busy_next = 1'b1;
            step_next = '0;
        end
        else if (busy_reg)
        begin
            unique case (ctrl.jmp_cond)
                JMP_SEQ:
                begin
                    step_next = step_reg + 1'b1;
                end
                JMP_OUT_WAIT:
                begin
                    if (out_stall)
                    begin
                        step_next = ctrl.jmp_target;
                    end
                    else
                    begin
                        fire_out  = 1'b1;
                        busy_next = 1'b0;
                    end
                end
            endcase
        end
    end

    // Accumulator: load the scaled sample, then add or clear per control word
    always_comb
    begin
        acc_next = acc_reg;
        if (sample_take)
        begin
            acc_next = {{(ACC_W-SAMPLE_BITS-COEF_FRAC){sample_in[SAMPLE_BITS-1]}},
                        sample_in, {COEF_FRAC{1'b0}}};
        end
        else if (busy_reg)
        begin
            case (ctrl.acc_op)
                ACC_ADD: acc_next = acc_reg
                                    + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
                ACC_CLR: acc_next = '0;
                default: acc_next = acc_reg;
            endcase
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (fire_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Coefficient registers; drop writes to unused indexes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fb1_reg <= '0;
            fb2_reg <= '0;
            ff0_reg <= '0;
            ff1_reg <= '0;
            ff2_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_FB_COEF_1: fb1_reg <= cfg_data;
                REG_FB_COEF_2: fb2_reg <= cfg_data;
                REG_FF_COEF_0: ff0_reg <= cfg_data;
                REG_FF_COEF_1: ff1_reg <= cfg_data;
                REG_FF_COEF_2: ff2_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    // Delay line: load on a load transaction, shift when a result leaves
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d1_reg <= '0;
            d2_reg <= '0;
        end
        else if (load_take)
        begin
            d1_reg <= load_first;
            d2_reg <= load_second;
        end
        else if (fire_out)
        begin
            d1_reg <= w_reg;
            d2_reg <= d1_reg;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod;
        acc_reg  <= acc_next;
        if (busy_reg && ctrl.w_wr)
        begin
            w_reg <= w_val;
        end
        if (fire_out)
        begin
            out_data_reg <= y_val;
        end
    end

endmodule

// ----- sv/bqdf2_checker.sv -----
// Port-level checker for the biquad and its bind to the top level.
`include "biquad_direct_form_two_assert.svh"

module bqdf2_checker
    import bqdf2_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DFLT
)
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_ready,
    input logic                   req_type,
    input logic                   out_valid,
    input logic                   out_ready,
    input logic [SAMPLE_BITS-1:0] sample_out
);

    // A held result keeps its value
    `BQDF2_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample_out))

    // A load transaction never produces a result
    `BQDF2_ASSERT_NXT(a_load_silent, clk, rst_n, in_valid && in_ready && (req_type == REQ_LOAD), !$rose(out_valid))

    // A sample transaction occupies the sequencer
    `BQDF2_ASSERT_NXT(a_sample_busy, clk, rst_n, in_valid && in_ready && (req_type == REQ_SAMPLE), !in_ready)

    // A result only appears at the end of a busy program
    `BQDF2_ASSERT_IMP(a_out_from_busy, clk, rst_n, $rose(out_valid), !$past(in_ready))

endmodule

bind biquad_direct_form_two bqdf2_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_bqdf2_checker (.*);
